// File: hw/rtl/pia_pkg.sv
// Shared types and constants for the parallel interface adapter block.
// Used by pia_core and pia_port_and_command_latch; depends on nothing.
package pia_pkg;

   localparam logic [1:0] MODE_READ    = 2'd0;
   localparam logic [1:0] MODE_WRITE   = 2'd1;
   localparam logic [1:0] MODE_COMMAND = 2'd2;

   localparam logic [7:0] CTRL_ACCESS_MASK  = 8'h04;
   localparam logic [7:0] CTRL_KEEP_MASK    = 8'h3f;
   localparam logic [7:0] CTRL_FLAGS_MASK   = 8'hc0;
   localparam logic [7:0] CTRL_FLAG7_MASK   = 8'h80;
   localparam logic [7:0] CTRL_RISE_MASK    = 8'h02;
   localparam logic [7:0] CTRL_ENABLE_MASK  = 8'h01;
   localparam logic [7:0] COMMAND_IDLE_BYTE = 8'hff;

   localparam int REQ_TDATA_WIDTH = 8;
   localparam int REQ_TUSER_WIDTH = 4;
   localparam int RSP_TDATA_WIDTH = 24;
   localparam int RSP_PAD_WIDTH   = 7;

   typedef struct packed {
      logic [1:0] register_select;
      logic [1:0] mode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] dac_output;
      logic       irq;
      logic [7:0] read_data;
   } rsp_type;

endpackage

// File: hw/rtl/pia_core.sv
// Register file and update logic of the adapter: ports, control, command latch, DAC.
// Depends on pia_pkg for the request and result types and the control masks.
module pia_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  pia_pkg::req_type req,
   output pia_pkg::rsp_type rsp
);

   logic [7:0] dir_ff  [2];
   logic [7:0] dir_in  [2];
   logic [7:0] outl_ff [2];
   logic [7:0] outl_in [2];
   logic [7:0] ctrl_ff [2];
   logic [7:0] ctrl_in [2];
   logic       cb1_ff;
   logic       cb1_in;
   logic [7:0] cmd_ff;
   logic [7:0] cmd_in;
   logic [7:0] dac_ff;
   logic [7:0] dac_in;

   logic       port;
   logic       is_ctrl;
   logic       line;
   logic       want_rise;
   logic [7:0] pins;
   logic [7:0] read_data;
   logic       irq_a;
   logic       irq_b;

   assign port    = req.register_select[1];
   assign is_ctrl = req.register_select[0];
   assign pins    = port ? cmd_ff : outl_ff[0];
   assign line    = (req.data_byte != pia_pkg::COMMAND_IDLE_BYTE);
   assign want_rise = ((ctrl_ff[1] & pia_pkg::CTRL_RISE_MASK) != 8'h00);

   always_comb begin
      dir_in    = dir_ff;
      outl_in   = outl_ff;
      ctrl_in   = ctrl_ff;
      cb1_in    = cb1_ff;
      cmd_in    = cmd_ff;
      dac_in    = dac_ff;
      read_data = 8'h00;
      case (req.mode)
         pia_pkg::MODE_READ: begin
            if (is_ctrl) begin
               read_data = ctrl_ff[port];
            end else if ((ctrl_ff[port] & pia_pkg::CTRL_ACCESS_MASK) == 8'h00) begin
               read_data = dir_ff[port];
            end else begin
               ctrl_in[port] = ctrl_ff[port] & pia_pkg::CTRL_KEEP_MASK;
               read_data = (pins & ~dir_ff[port]) | (outl_ff[port] & dir_ff[port]);
            end
         end
         pia_pkg::MODE_WRITE: begin
            if (is_ctrl) begin
               ctrl_in[port] = (ctrl_ff[port] & pia_pkg::CTRL_FLAGS_MASK) |
                               (req.data_byte & pia_pkg::CTRL_KEEP_MASK);
            end else if ((ctrl_ff[port] & pia_pkg::CTRL_ACCESS_MASK) == 8'h00) begin
               dir_in[port] = req.data_byte;
            end else begin
               outl_in[port] = req.data_byte;
               if (!port) begin
                  dac_in = req.data_byte;
               end
            end
         end
         pia_pkg::MODE_COMMAND: begin
            cmd_in = req.data_byte;
            if (line != cb1_ff) begin
               if (line == want_rise) begin
                  ctrl_in[1] = ctrl_ff[1] | pia_pkg::CTRL_FLAG7_MASK;
               end
               cb1_in = line;
            end
         end
         default: begin
         end
      endcase
   end

   assign irq_a = ((ctrl_in[0] & pia_pkg::CTRL_FLAG7_MASK) != 8'h00) &&
                  ((ctrl_in[0] & pia_pkg::CTRL_ENABLE_MASK) != 8'h00);
   assign irq_b = ((ctrl_in[1] & pia_pkg::CTRL_FLAG7_MASK) != 8'h00) &&
                  ((ctrl_in[1] & pia_pkg::CTRL_ENABLE_MASK) != 8'h00);

   assign rsp.read_data  = read_data;
   assign rsp.irq        = irq_a || irq_b;
   assign rsp.dac_output = dac_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff  <= '{default: 8'h00};
         outl_ff <= '{default: 8'h00};
         ctrl_ff <= '{default: 8'h00};
         cb1_ff  <= 1'b0;
         cmd_ff  <= pia_pkg::COMMAND_IDLE_BYTE;
         dac_ff  <= 8'h00;
      end else if (step) begin
         dir_ff  <= dir_in;
         outl_ff <= outl_in;
         ctrl_ff <= ctrl_in;
         cb1_ff  <= cb1_in;
         cmd_ff  <= cmd_in;
         dac_ff  <= dac_in;
      end
   end

endmodule

// File: hw/rtl/pia_port_and_command_latch.sv
// Top level of the parallel interface adapter: request register, core, result register.
// Depends on pia_pkg and pia_core.
//
//   channel | dir | tdata (low bit up)                   | tuser (low bit up)
//   req_    | in  | data_byte[7:0]                       | mode[1:0], register_select[3:2]
//   rsp_    | out | read_data[7:0], irq[8], dac[16:9]    | none
//
// One request is taken per cycle unless a stalled result holds a full request register.
// The request register feeds the core, which updates its registers as the result
// moves into the result register, so the rate is set by that single stage. A stalled
// result holds the pipeline; requests are still taken while the request register is free
// or drains. Reset clears valid bits and core registers; the command latch resets to 0xff.
module pia_port_and_command_latch (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pia_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,  // data_byte
   input  logic [pia_pkg::REQ_TUSER_WIDTH-1:0] req_tuser,  // mode, register_select
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pia_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata   // read_data, irq, dac_output
);

   pia_pkg::req_type in_ff;
   pia_pkg::req_type in_in;
   logic             in_valid_ff;
   pia_pkg::rsp_type out_ff;
   pia_pkg::rsp_type core_rsp;
   logic             out_valid_ff;
   logic             advance;
   logic             step;
   logic             req_take;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign step       = in_valid_ff && advance;

   assign in_in.data_byte       = req_tdata;
   assign in_in.mode            = req_tuser[1:0];
   assign in_in.register_select = req_tuser[3:2];

   pia_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (in_ff),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= in_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= core_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{pia_pkg::RSP_PAD_WIDTH{1'b0}}, out_ff};

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!in_valid_ff && !out_valid_ff))
      else $error("pipeline not empty after reset");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request register overwritten during stall");

   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      (step && in_ff.mode != pia_pkg::MODE_READ) |=> (rsp_tdata[7:0] == 8'h00))
      else $error("read data not zero for a non-read request");

   a_step_fills: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_tvalid)
      else $error("processed request produced no result");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for pia_port_and_command_latch: a directed table and then random bus requests,
// each checked against typed row values or a local model. Depends on pia_pkg and the RTL.
module tb_top;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [1:0] SEL_A_DATA  = 2'd0;
   localparam logic [1:0] SEL_A_CTRL  = 2'd1;
   localparam logic [1:0] SEL_B_DATA  = 2'd2;
   localparam logic [1:0] SEL_B_CTRL  = 2'd3;
   localparam int RANDOM_ITEMS = 1925;
   localparam int DIRECTED_ROWS = 25;

   typedef struct packed {
      logic [1:0] mode;
      logic [1:0] sel;
      logic [7:0] data;
      logic       typed;
      logic [7:0] want_read;
      logic       want_irq;
      logic [7:0] want_dac;
   } stim_row_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [pia_pkg::REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   logic [pia_pkg::REQ_TUSER_WIDTH-1:0] req_tuser = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [pia_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata;

   logic [7:0] direction_reg [2];
   logic [7:0] output_latch [2];
   logic [7:0] control_reg [2];
   logic       cb1_line;
   logic [7:0] command_byte;
   logic [7:0] dac_byte;

   pia_pkg::rsp_type results_due [$];
   int      error_count = 0;
   int      hold_off_cycles = 0;
   int      send_quiet_left = 0;
   int      reads_sent = 0;
   int      writes_sent = 0;
   int      commands_sent = 0;
   int      unused_sent = 0;
   int      results_checked = 0;
   int      irq_high_seen = 0;

   stim_row_type directed_table [DIRECTED_ROWS] = '{
      '{pia_pkg::MODE_READ,    SEL_A_DATA, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00},
      '{pia_pkg::MODE_READ,    SEL_B_CTRL, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00},
      '{pia_pkg::MODE_WRITE,   SEL_A_DATA, 8'hff, 1'b0, 8'h00, 1'b0, 8'h00},
      '{pia_pkg::MODE_WRITE,   SEL_A_CTRL, 8'hff, 1'b0, 8'h00, 1'b0, 8'h00},
      '{pia_pkg::MODE_READ,    SEL_A_CTRL, 8'h00, 1'b1, 8'h3f, 1'b0, 8'h00},
      '{pia_pkg::MODE_WRITE,   SEL_A_DATA, 8'ha5, 1'b0, 8'h00, 1'b0, 8'h00},
      '{pia_pkg::MODE_WRITE,   SEL_A_DATA, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{pia_pkg::MODE_WRITE,   SEL_A_DATA, 8'hff, 1'b0, 8'h00, 1'b0, 8'h00},
      '{pia_pkg::MODE_READ,    SEL_A_DATA, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{pia_pkg::MODE_WRITE,   SEL_B_CTRL, 8'h07, 1'b0, 8'h00, 1'b0, 8'h00},
      '{pia_pkg::MODE_COMMAND, SEL_A_DATA, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{pia_pkg::MODE_READ,    SEL_B_CTRL, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{pia_pkg::MODE_READ,    SEL_B_DATA, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{pia_pkg::MODE_COMMAND, SEL_B_DATA, 8'h5a, 1'b0, 8'h00, 1'b0, 8'h00},
      '{pia_pkg::MODE_COMMAND, SEL_A_CTRL, pia_pkg::COMMAND_IDLE_BYTE, 1'b0, 8'h00, 1'b0,
        8'h00},
      '{pia_pkg::MODE_WRITE,   SEL_B_CTRL, 8'h05, 1'b0, 8'h00, 1'b0, 8'h00},
      '{pia_pkg::MODE_COMMAND, SEL_B_CTRL, 8'h12, 1'b0, 8'h00, 1'b0, 8'h00},
      '{pia_pkg::MODE_COMMAND, SEL_A_DATA, pia_pkg::COMMAND_IDLE_BYTE, 1'b0, 8'h00, 1'b0,
        8'h00},
      '{pia_pkg::MODE_WRITE,   SEL_B_CTRL, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{pia_pkg::MODE_WRITE,   SEL_B_DATA, 8'h0f, 1'b0, 8'h00, 1'b0, 8'h00},
      '{pia_pkg::MODE_WRITE,   SEL_B_CTRL, 8'h3c, 1'b0, 8'h00, 1'b0, 8'h00},
      '{pia_pkg::MODE_WRITE,   SEL_B_DATA, 8'h33, 1'b0, 8'h00, 1'b0, 8'h00},
      '{pia_pkg::MODE_READ,    SEL_B_DATA, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{MODE_UNUSED,           SEL_B_DATA, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{MODE_UNUSED,           SEL_A_CTRL, 8'hff, 1'b0, 8'h00, 1'b0, 8'h00}
   };

   pia_port_and_command_latch dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic clear_adapter_state();
      for (int p = 0; p < 2; p++) begin
         direction_reg[p] = 8'h00;
         output_latch[p] = 8'h00;
         control_reg[p] = 8'h00;
      end
      cb1_line = 1'b0;
      command_byte = pia_pkg::COMMAND_IDLE_BYTE;
      dac_byte = 8'h00;
   endtask

   function automatic pia_pkg::rsp_type step_adapter(input logic [1:0] mode,
                                                     input logic [1:0] sel,
                                                     input logic [7:0] data);
      logic             port;
      logic             line;
      logic             want_rise;
      logic [7:0]       pins;
      pia_pkg::rsp_type result;
      port = sel[1];
      result = '0;
      case (mode)
         pia_pkg::MODE_READ: begin
            if (sel[0]) begin
               result.read_data = control_reg[port];
            end else if ((control_reg[port] & pia_pkg::CTRL_ACCESS_MASK) == 8'h00) begin
               result.read_data = direction_reg[port];
            end else begin
               control_reg[port] = control_reg[port] & pia_pkg::CTRL_KEEP_MASK;
               pins = port ? command_byte : output_latch[0];
               result.read_data = (pins & ~direction_reg[port]) |
                                  (output_latch[port] & direction_reg[port]);
            end
         end
         pia_pkg::MODE_WRITE: begin
            if (sel[0]) begin
               control_reg[port] = (control_reg[port] & pia_pkg::CTRL_FLAGS_MASK) |
                                   (data & pia_pkg::CTRL_KEEP_MASK);
            end else if ((control_reg[port] & pia_pkg::CTRL_ACCESS_MASK) == 8'h00) begin
               direction_reg[port] = data;
            end else begin
               output_latch[port] = data;
               if (!port) dac_byte = data;
            end
         end
         pia_pkg::MODE_COMMAND: begin
            line = (data != pia_pkg::COMMAND_IDLE_BYTE);
            command_byte = data;
            if (line != cb1_line) begin
               want_rise = (control_reg[1] & pia_pkg::CTRL_RISE_MASK) != 8'h00;
               if (line == want_rise) begin
                  control_reg[1] = control_reg[1] | pia_pkg::CTRL_FLAG7_MASK;
               end
               cb1_line = line;
            end
         end
         default: begin
         end
      endcase
      for (int p = 0; p < 2; p++) begin
         if ((control_reg[p] & pia_pkg::CTRL_FLAG7_MASK) != 8'h00 &&
             (control_reg[p] & pia_pkg::CTRL_ENABLE_MASK) != 8'h00) result.irq = 1'b1;
      end
      result.dac_output = dac_byte;
      return result;
   endfunction

   function automatic int pick_send_gap();
      int roll;
      if (send_quiet_left > 0) begin
         send_quiet_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         send_quiet_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offers one request, waits for its acceptance, records the result it must cause,
   // and then leaves a random gap before the next request.
   task automatic issue_request(input logic [1:0] mode, input logic [1:0] sel,
                                input logic [7:0] data, input logic typed,
                                input pia_pkg::rsp_type typed_result);
      logic             fire;
      int               gap;
      pia_pkg::rsp_type predicted;
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= {sel, mode};
      do begin
         @(negedge clock);
         fire = req_tready;
         @(posedge clock);
      end while (!fire);
      predicted = step_adapter(mode, sel, data);
      results_due.push_back(typed ? typed_result : predicted);
      case (mode)
         pia_pkg::MODE_READ:    reads_sent++;
         pia_pkg::MODE_WRITE:   writes_sent++;
         pia_pkg::MODE_COMMAND: commands_sent++;
         default:               unused_sent++;
      endcase
      gap = pick_send_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      int quiet_left;
      int stall_left;
      int roll;
      quiet_left = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (quiet_left > 0) begin
            quiet_left--;
            rsp_tready <= 1'b1;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               quiet_left = $urandom_range(30, 120);
               rsp_tready <= 1'b1;
            end else if (roll < 25) begin
               stall_left = $urandom_range(0, 2);
               rsp_tready <= 1'b0;
            end else if (roll < 28) begin
               stall_left = $urandom_range(9, 39);
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   always @(negedge clock) begin
      pia_pkg::rsp_type seen;
      pia_pkg::rsp_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[$bits(pia_pkg::rsp_type)-1:0];
         if (results_due.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_tdata);
            error_count++;
         end else begin
            due = results_due.pop_front();
            results_checked++;
            if (seen.irq) irq_high_seen++;
            if (seen.read_data !== due.read_data) begin
               $error("read_data: expected %h, got %h", due.read_data, seen.read_data);
               error_count++;
            end
            if (seen.irq !== due.irq) begin
               $error("irq: expected %b, got %b", due.irq, seen.irq);
               error_count++;
            end
            if (seen.dac_output !== due.dac_output) begin
               $error("dac_output: expected %h, got %h", due.dac_output, seen.dac_output);
               error_count++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int               counted;
      int               item_index;
      int               drain_wait;
      int               roll;
      logic [1:0]       mode;
      logic [1:0]       sel;
      logic [7:0]       data;
      pia_pkg::rsp_type typed_result;
      clear_adapter_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_table[i]) begin
         typed_result.read_data = directed_table[i].want_read;
         typed_result.irq = directed_table[i].want_irq;
         typed_result.dac_output = directed_table[i].want_dac;
         issue_request(directed_table[i].mode, directed_table[i].sel, directed_table[i].data,
                       directed_table[i].typed, typed_result);
      end

      counted = 0;
      item_index = 0;
      while (counted < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 35) mode = pia_pkg::MODE_READ;
         else if (roll < 68) mode = pia_pkg::MODE_WRITE;
         else if (roll < 97) mode = pia_pkg::MODE_COMMAND;
         else mode = MODE_UNUSED;
         sel = 2'($urandom_range(0, 3));
         roll = $urandom_range(0, 99);
         if (roll < 8) data = 8'h00;
         else if (roll < 16) data = 8'hff;
         else data = 8'($urandom_range(0, 255));
         if (mode == pia_pkg::MODE_COMMAND && $urandom_range(0, 1)) begin
            data = pia_pkg::COMMAND_IDLE_BYTE;
         end
         if (item_index == 600) hold_off_cycles = 400;
         issue_request(mode, sel, data, 1'b0, '0);
         if (mode != MODE_UNUSED) counted++;
         if (item_index == 1200) begin
            req_tvalid <= 1'b0;
            while (results_due.size() != 0) @(posedge clock);
         end
         item_index++;
      end

      req_tvalid <= 1'b0;
      drain_wait = 0;
      while (results_due.size() != 0 && drain_wait < 5000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (8) @(posedge clock);
      if (results_due.size() != 0) begin
         $error("%0d responses never arrived", results_due.size());
         error_count++;
      end
      $display("Sent %0d reads, %0d writes, %0d command bytes and %0d unused-mode requests.",
               reads_sent, writes_sent, commands_sent, unused_sent);
      $display("Checked %0d responses, %0d of them with the interrupt line high.",
               results_checked, irq_high_seen);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
